// File: sv/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list package
// Shared widths, operation and status codes, and item types.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int POS_W      = 7;
   localparam int WORD_W     = 32;

   localparam logic [2:0] OP_INSERT_AT    = 3'd0;
   localparam logic [2:0] OP_INSERT_FRONT = 3'd1;
   localparam logic [2:0] OP_APPEND       = 3'd2;
   localparam logic [2:0] OP_DELETE_AT    = 3'd3;
   localparam logic [2:0] OP_MODIFY       = 3'd4;
   localparam logic [2:0] OP_READ         = 3'd5;
   localparam logic [2:0] OP_REMOVE_VALUE = 3'd6;
   localparam logic [2:0] OP_CLEAR        = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BADPOS   = 2'd2;
   localparam logic [1:0] ST_NOEFFECT = 2'd3;

   typedef struct packed {
      logic [2:0]              op;
      logic [POS_W-1:0]        position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] read_value;
      logic [CNT_W-1:0]         entry_count;
      logic                     is_full;
      logic                     is_empty;
   } rsp_type;

endpackage

// File: sv/positional_array_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list core
// Ordered list of signed words held in one synchronous RAM, with in-place
// insert, delete, overwrite, read, value removal and clear.
// ----------------------------------------------------------------------------
// Modify, clear and rejected items answer in the cycle after accept;
//    read passes through S_READ and the registered RAM read before answering.
// Insert, delete and value removal step through S_MOVE and answer once the
//    last entry has been written back; the RAM moves one entry a cycle.
// One item at a time: busy is high while an item is in S_MOVE or S_READ and falls as its result is issued.
// Reset clears the count and control state; RAM contents are not cleared.
// The receiver cannot stall: every result appears for one cycle on rsp_strobe.
module positional_array_list_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pal_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output pal_pkg::rsp_type  rsp_data
);
   import pal_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MOVE = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

   logic [WORD_W-1:0] mem_entries [LIST_DEPTH];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic [1:0]        state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CNT_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [1:0]        status_nx;
   logic [WORD_W-1:0] rdval_nx;
   logic [POS_W-1:0]  ins_pos;
   logic              req_pos_ok;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (req_data.op == OP_INSERT_FRONT) begin
         ins_pos = '0;
      end else if (req_data.op == OP_APPEND) begin
         ins_pos = POS_W'(count_ff);
      end else begin
         ins_pos = req_data.position;
      end
   end

   assign req_pos_ok = (req_data.position < POS_W'(count_ff));

   // RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_entries[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem_entries[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      left_in      = left_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = rd_ptr_ff[ADDR_W-1:0];
      rsp_valid_in = 1'b0;
      status_nx    = ST_OK;
      rdval_nx     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_data.op;
               val_in = req_data.value;
               pos_in = CNT_W'(req_data.position);
               unique case (req_data.op)
                  OP_INSERT_AT, OP_INSERT_FRONT, OP_APPEND: begin
                     if (count_ff == DEPTH_CNT) begin
                        status_nx    = ST_FULL;
                        rsp_valid_in = 1'b1;
                     end else if (ins_pos > POS_W'(count_ff)) begin
                        status_nx    = ST_BADPOS;
                        rsp_valid_in = 1'b1;
                     end else begin
                        // shift the entries at ins_pos and above up by one, top first
                        op_in     = OP_INSERT_AT;
                        pos_in    = CNT_W'(ins_pos);
                        left_in   = count_ff - CNT_W'(ins_pos);
                        rd_ptr_in = count_ff - CNT_W'(1);
                        state_in  = S_MOVE;
                     end
                  end
                  OP_DELETE_AT: begin
                     if (req_pos_ok) begin
                        left_in   = count_ff - CNT_W'(req_data.position) - CNT_W'(1);
                        rd_ptr_in = CNT_W'(req_data.position) + CNT_W'(1);
                        state_in  = S_MOVE;
                     end else begin
                        status_nx    = ST_NOEFFECT;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_MODIFY: begin
                     if (req_pos_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_data.position[ADDR_W-1:0];
                        mem_wdata = req_data.value;
                     end else begin
                        status_nx = ST_BADPOS;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_READ: begin
                     if (req_pos_ok) begin
                        mem_raddr = req_data.position[ADDR_W-1:0];
                        state_in  = S_READ;
                     end else begin
                        status_nx    = ST_BADPOS;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_REMOVE_VALUE: begin
                     left_in   = count_ff;
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     state_in  = S_MOVE;
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_MOVE: begin
            // issue the next read
            if (left_ff != '0) begin
               mem_raddr    = rd_ptr_ff[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = rd_ptr_ff[ADDR_W-1:0];
               left_in      = left_ff - CNT_W'(1);
               if (op_ff == OP_INSERT_AT) begin
                  rd_ptr_in = rd_ptr_ff - CNT_W'(1);
               end else begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               end
            end
            // write back the word read last cycle
            if (pend_ff) begin
               mem_wdata = mem_rdata_ff;
               if (op_ff == OP_INSERT_AT) begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_addr_ff + ADDR_W'(1);
               end else if (op_ff == OP_DELETE_AT) begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_addr_ff - ADDR_W'(1);
               end else if (mem_rdata_ff != val_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ptr_ff[ADDR_W-1:0];
                  wr_ptr_in = wr_ptr_ff + CNT_W'(1);
               end
            end
            if (left_ff == '0 && !pend_ff) begin
               if (op_ff == OP_INSERT_AT) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff[ADDR_W-1:0];
                  mem_wdata = val_ff;
                  count_in  = count_ff + CNT_W'(1);
               end else if (op_ff == OP_DELETE_AT) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  count_in = wr_ptr_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_READ: begin
            rdval_nx     = mem_rdata_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.status      = status_nx;
      rsp_in.read_value  = rdval_nx;
      rsp_in.entry_count = count_in;
      rsp_in.is_full     = (count_in == DEPTH_CNT);
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      rd_ptr_ff    <= rd_ptr_in;
      left_ff      <= left_in;
      wr_ptr_ff    <= wr_ptr_in;
      pend_addr_ff <= pend_addr_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count exceeds list depth");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_full == (rsp_data.entry_count == DEPTH_CNT)))
      else $error("full flag disagrees with entry count");

   a_read_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.read_value != '0) |-> (rsp_data.status == ST_OK))
      else $error("nonzero read value on a failed item");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_CLEAR)
      |=> rsp_strobe && (rsp_data.entry_count == '0))
      else $error("clear did not empty the list");

   a_move_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> (left_ff <= count_ff))
      else $error("move counter exceeds entry count");

endmodule

// File: dv/tb_positional_array_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list core testbench
// Sends list operations through the start/busy command port and keeps a
// shadow copy of the list that predicts every result. Each strobed result is
// checked field by field against the oldest prediction. Directed corner cases
// come first, then full-list and duplicate-removal sequences and random mixes.
// ----------------------------------------------------------------------------
module tb_positional_array_list_core;
   import pal_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   positional_array_list_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic signed [WORD_W-1:0] shadow_words [LIST_DEPTH];
   int unsigned              shadow_len;
   rsp_type                  pending_rsp [$];
   rsp_type                  due_rsp;
   bit                       idle_on;
   int                       mismatch_count;
   int                       items_sent;
   int                       results_seen;
   int                       idle_cycles;
   int unsigned              peak_len;
   int                       op_seen [8];
   int                       status_seen [4];

   function automatic req_type list_req(logic [2:0] op, int pos, int val);
      req_type item;
      item.op       = op;
      item.position = POS_W'(pos);
      item.value    = val;
      return item;
   endfunction

   // Apply one item to the shadow list and return the result it should give.
   function automatic rsp_type apply_list_op(req_type item);
      rsp_type     res;
      int unsigned pos, keep, i;
      res        = '0;
      res.status = ST_OK;
      pos        = 32'(item.position);
      case (item.op)
         OP_INSERT_AT, OP_INSERT_FRONT, OP_APPEND: begin
            if (item.op == OP_INSERT_FRONT) pos = 0;
            if (item.op == OP_APPEND) pos = shadow_len;
            // full wins over a bad position
            if (shadow_len >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else if (pos > shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i - 1];
               shadow_words[pos] = item.value;
               shadow_len++;
            end
         end
         OP_DELETE_AT: begin
            if (pos < shadow_len) begin
               for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i + 1];
               shadow_len--;
            end else begin
               res.status = ST_NOEFFECT;
            end
         end
         OP_MODIFY: begin
            if (pos < shadow_len) shadow_words[pos] = item.value;
            else res.status = ST_BADPOS;
         end
         OP_READ: begin
            if (pos < shadow_len) res.read_value = shadow_words[pos];
            else res.status = ST_BADPOS;
         end
         OP_REMOVE_VALUE: begin
            keep = 0;
            for (i = 0; i < shadow_len; i++) begin
               if (shadow_words[i] != item.value) begin
                  shadow_words[keep] = shadow_words[i];
                  keep++;
               end
            end
            shadow_len = keep;
         end
         OP_CLEAR: begin
            shadow_len = 0;
         end
      endcase
      res.entry_count = CNT_W'(shadow_len);
      res.is_full     = (shadow_len == LIST_DEPTH);
      res.is_empty    = (shadow_len == 0);
      return res;
   endfunction

   function automatic void check_field(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Random item, mostly at legal positions, values drawn so that removal
   // finds matches and the list fills up now and then.
   function automatic req_type random_list_req();
      logic [2:0]               op;
      int unsigned              roll, hi;
      int                       pos;
      logic signed [WORD_W-1:0] val;
      roll = $urandom_range(0, 999);
      if (roll < 180)      op = OP_INSERT_AT;
      else if (roll < 280) op = OP_INSERT_FRONT;
      else if (roll < 420) op = OP_APPEND;
      else if (roll < 580) op = OP_DELETE_AT;
      else if (roll < 680) op = OP_MODIFY;
      else if (roll < 870) op = OP_READ;
      else if (roll < 996) op = OP_REMOVE_VALUE;
      else                 op = OP_CLEAR;
      // keep a full list from soaking up most inserts
      if ((op == OP_INSERT_AT || op == OP_INSERT_FRONT || op == OP_APPEND) &&
          shadow_len == LIST_DEPTH && $urandom_range(0, 3) != 0)
         op = OP_DELETE_AT;

      hi   = (op == OP_INSERT_AT) ? shadow_len : ((shadow_len == 0) ? 0 : shadow_len - 1);
      roll = $urandom_range(0, 19);
      if (roll == 0)     pos = $urandom_range(0, 127);
      else if (roll < 3) pos = hi + $urandom_range(1, 3);
      else               pos = $urandom_range(0, hi);

      roll = $urandom_range(0, 9);
      if (op == OP_REMOVE_VALUE && shadow_len != 0 && roll < 7)
         val = shadow_words[$urandom_range(0, shadow_len - 1)];
      else if (roll < 4)
         val = $urandom_range(0, 5) - 2;
      else if (roll == 4)
         val = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else
         val = $urandom;
      return list_req(op, pos, val);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input req_type item);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_list_op(item));
      op_seen[item.op]++;
      items_sent++;
      if (shadow_len > peak_len) peak_len = shadow_len;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: status %0h, entry_count %0d",
                   rsp_data.status, rsp_data.entry_count);
            mismatch_count++;
         end else begin
            due_rsp = pending_rsp.pop_front();
            results_seen++;
            status_seen[due_rsp.status]++;
            check_field("status", WORD_W'(due_rsp.status), WORD_W'(rsp_data.status));
            check_field("read_value", due_rsp.read_value, rsp_data.read_value);
            check_field("entry_count", WORD_W'(due_rsp.entry_count),
                        WORD_W'(rsp_data.entry_count));
            check_field("is_full", WORD_W'(due_rsp.is_full), WORD_W'(rsp_data.is_full));
            check_field("is_empty", WORD_W'(due_rsp.is_empty), WORD_W'(rsp_data.is_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_strobe)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no item or result for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic test_directed_cases();
      // empty list: every position is bad, removal and clear still succeed
      send_item(list_req(OP_READ, 0, 0));
      send_item(list_req(OP_DELETE_AT, 0, 0));
      send_item(list_req(OP_MODIFY, 0, 1));
      send_item(list_req(OP_REMOVE_VALUE, 0, 0));
      send_item(list_req(OP_CLEAR, 0, 0));
      send_item(list_req(OP_INSERT_AT, 1, 7));
      // build a short list with the extreme words
      send_item(list_req(OP_INSERT_AT, 0, 32'sh7fffffff));
      send_item(list_req(OP_INSERT_FRONT, 0, 32'sh80000000));
      send_item(list_req(OP_APPEND, 0, -1));
      send_item(list_req(OP_INSERT_AT, 3, 0));
      send_item(list_req(OP_INSERT_AT, 1, 5));
      for (int p = 0; p <= 5; p++) send_item(list_req(OP_READ, p, 0));
      send_item(list_req(OP_MODIFY, 4, 5));
      send_item(list_req(OP_REMOVE_VALUE, 0, 5));
      send_item(list_req(OP_REMOVE_VALUE, 0, 12345));
      send_item(list_req(OP_READ, 127, 0));
      send_item(list_req(OP_DELETE_AT, 127, 0));
      send_item(list_req(OP_MODIFY, 127, 9));
      send_item(list_req(OP_DELETE_AT, 0, 0));
      send_item(list_req(OP_DELETE_AT, 1, 0));
      send_item(list_req(OP_CLEAR, 0, 0));
      send_item(list_req(OP_READ, 0, 0));
   endtask

   task automatic test_full_list();
      send_item(list_req(OP_CLEAR, 0, 0));
      while (shadow_len < LIST_DEPTH) begin
         case ($urandom_range(0, 2))
            0: send_item(list_req(OP_APPEND, 0, $urandom));
            1: send_item(list_req(OP_INSERT_FRONT, 0, $urandom));
            default: send_item(list_req(OP_INSERT_AT, $urandom_range(0, shadow_len), $urandom));
         endcase
      end
      send_item(list_req(OP_INSERT_AT, 127, 0));
      send_item(list_req(OP_INSERT_AT, LIST_DEPTH, 0));
      send_item(list_req(OP_INSERT_FRONT, 0, -1));
      send_item(list_req(OP_APPEND, 0, -1));
      send_item(list_req(OP_READ, LIST_DEPTH - 1, 0));
      send_item(list_req(OP_READ, LIST_DEPTH, 0));
      send_item(list_req(OP_MODIFY, LIST_DEPTH - 1, 32'sh7fffffff));
      send_item(list_req(OP_DELETE_AT, LIST_DEPTH, 0));
      // longest shifts in both directions
      send_item(list_req(OP_DELETE_AT, 0, 0));
      send_item(list_req(OP_INSERT_AT, 0, 32'sh80000000));
      send_item(list_req(OP_DELETE_AT, LIST_DEPTH - 1, 0));
      send_item(list_req(OP_INSERT_AT, LIST_DEPTH - 1, 5));
      send_item(list_req(OP_READ, 0, 0));
      send_item(list_req(OP_REMOVE_VALUE, 0, 32'sh80000000));
      send_item(list_req(OP_CLEAR, 0, 0));
   endtask

   task automatic test_remove_duplicates();
      int fill, v;
      repeat (3) begin
         send_item(list_req(OP_CLEAR, 0, 0));
         fill = $urandom_range(8, LIST_DEPTH);
         repeat (fill) send_item(list_req(OP_APPEND, 0, $urandom_range(0, 2) - 1));
         // strip one value at a time and sample what is left
         for (v = -1; v <= 1; v++) begin
            send_item(list_req(OP_REMOVE_VALUE, 0, v));
            repeat (4) begin
               if (shadow_len != 0)
                  send_item(list_req(OP_READ, $urandom_range(0, shadow_len - 1), 0));
            end
         end
         send_item(list_req(OP_REMOVE_VALUE, 0, 0));
      end
   endtask

   task automatic test_random_mix(input int n);
      for (int k = 0; k < n; k++) begin
         // switch idling on or off every hundred items
         if (k % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_item(random_list_req());
      end
   endtask

   task automatic test_back_to_back(input int n);
      idle_on = 1'b0;
      repeat (n) send_item(random_list_req());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset   <= 1'b0;
      idle_on  = 1'b1;
      test_directed_cases();
      test_full_list();
      test_remove_duplicates();
      test_random_mix(1200);
      test_back_to_back(250);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items: insert at %0d, front %0d, append %0d, delete %0d, modify %0d,",
               items_sent, op_seen[OP_INSERT_AT], op_seen[OP_INSERT_FRONT],
               op_seen[OP_APPEND], op_seen[OP_DELETE_AT], op_seen[OP_MODIFY]);
      $display("  read %0d, remove %0d, clear %0d; ok/full/bad/none %0d/%0d/%0d/%0d, %0s %0d",
               op_seen[OP_READ], op_seen[OP_REMOVE_VALUE], op_seen[OP_CLEAR],
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
               status_seen[ST_NOEFFECT], "longest list", peak_len);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
